@@ src/hdlcd_pkg.sv @@
// Shared constants, result type and CRC byte update for the HDLC deframer.
package hdlcd_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD  = 16'hF0B8;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [2:0]  ACK_MASK  = 3'h7;

  // frame status codes
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_CRC_ERR  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // fixed-width part of one result (length travels separately)
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;
    logic [7:0] frame_address;
    logic [7:0] frame_control;
    logic       ack_request;
    logic [2:0] ack_control;
  } res_t;

  // reflected CRC-16/CCITT, one byte per call
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/hdlcd_in_reg.sv @@
// Input register for received bytes.
module hdlcd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       vld,
  output logic [7:0] byte_q
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       load;

  assign in_stall = vld_r && !take;
  assign load     = in_valid && !in_stall;
  assign vld_nxt  = load ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign vld    = vld_r;
  assign byte_q = byte_r;

endmodule

@@ src/hdlcd_core.sv @@
// Unstuffing, CRC check, frame bookkeeping and tail delay.
module hdlcd_core #(
  parameter int PAYLOAD_MAX = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  logic [7:0]                           rx_byte,
  output logic                                 produce,
  output hdlcd_pkg::res_t                      res,
  output logic [$clog2(PAYLOAD_MAX + 1)-1:0]   res_len
);
  import hdlcd_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_MAX + 6);
  localparam int LEN_W = $clog2(PAYLOAD_MAX + 1);
  localparam logic [CNT_W-1:0] FRAME_MAX = CNT_W'(PAYLOAD_MAX + 4);
  localparam logic [CNT_W-1:0] CNT_OVF   = CNT_W'(PAYLOAD_MAX + 5);
  localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(4);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             esc_r, esc_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       ctl_r, ctl_nxt;
  logic [7:0]       tail_r [2];
  logic             tail_shift;
  logic [7:0]       d;
  logic [1:0]       status;
  logic             good;

  assign d = esc_r ? (rx_byte ^ ESC_XOR) : rx_byte;

  always_comb begin
    if (cnt_r > FRAME_MAX) begin
      status = ST_OVERFLOW;
    end else if (cnt_r < CNT_MIN) begin
      status = ST_SHORT;
    end else if (crc_r != CRC_GOOD) begin
      status = ST_CRC_ERR;
    end else begin
      status = ST_GOOD;
    end
  end
  assign good = (status == ST_GOOD);

  always_comb begin
    cnt_nxt    = cnt_r;
    esc_nxt    = esc_r;
    crc_nxt    = crc_r;
    addr_nxt   = addr_r;
    ctl_nxt    = ctl_r;
    tail_shift = 1'b0;
    produce    = 1'b0;
    res        = '0;
    res_len    = '0;
    if (fire) begin
      if (rx_byte == FLAG_BYTE) begin
        if (cnt_r != '0) begin
          produce            = 1'b1;
          res.kind           = KIND_STATUS;
          res.frame_status   = status;
          res.frame_address  = addr_r;
          res.frame_control  = ctl_r;
          if (good) begin
            res_len = LEN_W'(cnt_r - CNT_MIN);
            if (!ctl_r[0]) begin
              res.ack_request = 1'b1;
              res.ack_control = ctl_r[3:1] & ACK_MASK;
            end
          end
        end
        cnt_nxt  = '0;
        esc_nxt  = 1'b0;
        crc_nxt  = CRC_INIT;
        addr_nxt = '0;
        ctl_nxt  = '0;
      end else if (rx_byte == ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (cnt_r >= FRAME_MAX) begin
          cnt_nxt = CNT_OVF;
        end else begin
          crc_nxt = crc_feed(crc_r, d);
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == '0) begin
            addr_nxt = d;
          end else if (cnt_r == CNT_W'(1)) begin
            ctl_nxt = d;
          end else begin
            tail_shift = 1'b1;
            if (cnt_r >= CNT_MIN) begin
              produce          = 1'b1;
              res.kind         = KIND_PAYLOAD;
              res.payload_byte = tail_r[0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      esc_r  <= 1'b0;
      crc_r  <= CRC_INIT;
      addr_r <= '0;
      ctl_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      esc_r  <= esc_nxt;
      crc_r  <= crc_nxt;
      addr_r <= addr_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  // two-byte delay keeps the CRC bytes out of the payload stream
  always_ff @(posedge clk) begin
    if (tail_shift) begin
      tail_r[0] <= tail_r[1];
      tail_r[1] <= d;
    end
  end

endmodule

@@ src/hdlcd_out_reg.sv @@
// Result register on the output channel.
module hdlcd_out_reg #(
  parameter int PAYLOAD_MAX = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic                                 produce,
  input  hdlcd_pkg::res_t                      res,
  input  logic [$clog2(PAYLOAD_MAX + 1)-1:0]   res_len,
  output logic                                 room,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output hdlcd_pkg::res_t                      res_q,
  output logic [$clog2(PAYLOAD_MAX + 1)-1:0]   len_q
);
  import hdlcd_pkg::*;

  localparam int LEN_W = $clog2(PAYLOAD_MAX + 1);

  logic             vld_r, vld_nxt;
  res_t             res_r;
  logic [LEN_W-1:0] len_r;

  assign room    = !vld_r || !out_stall;
  assign vld_nxt = load ? produce : (out_stall ? vld_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && produce) begin
      res_r <= res;
      len_r <= res_len;
    end
  end

  assign out_valid = vld_r;
  assign res_q     = res_r;
  assign len_q     = len_r;

endmodule

@@ src/hdlc_deframer_crc16_check_top.sv @@
// Top level of the async HDLC deframer with CRC-16/CCITT check.
//
//   channel | direction | transaction moves
//   --------+-----------+---------------------------------------------------
//   in_     | input     | one raw received byte (flags, escapes included)
//   out_    | output    | one payload byte or one end-of-frame status
//
// Throughput is one byte per cycle while out_stall is low; a result goes from the
// input transaction through the input register, then the CRC/unstuff logic into
// the result register. The byte-wide CRC update sets the critical path.
// rst_n is synchronous, active low; it clears frame state and both valids.
// out_stall backs up into in_stall only while the result register is full;
// a new byte is still taken whenever the held byte can move on.
module hdlc_deframer_crc16_check_top #(
  parameter int PAYLOAD_MAX = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_kind,
  output logic [7:0]                           out_payload_byte,
  output logic [1:0]                           out_frame_status,
  output logic [7:0]                           out_frame_address,
  output logic [7:0]                           out_frame_control,
  output logic [$clog2(PAYLOAD_MAX + 1)-1:0]   out_payload_length,
  output logic                                 out_ack_request,
  output logic [2:0]                           out_ack_control
);
  import hdlcd_pkg::*;

  localparam int LEN_W = $clog2(PAYLOAD_MAX + 1);

  logic             byte_vld;
  logic [7:0]       byte_q;
  logic             room;
  logic             take;
  logic             produce;
  res_t             res;
  res_t             res_q;
  logic [LEN_W-1:0] res_len;

  // held byte advances when the result register can take its outcome
  assign take = byte_vld && room;

  hdlcd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .vld        (byte_vld),
    .byte_q     (byte_q)
  );

  hdlcd_core #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (take),
    .rx_byte (byte_q),
    .produce (produce),
    .res     (res),
    .res_len (res_len)
  );

  hdlcd_out_reg #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .produce   (produce),
    .res       (res),
    .res_len   (res_len),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (res_q),
    .len_q     (out_payload_length)
  );

  assign out_kind          = res_q.kind;
  assign out_payload_byte  = res_q.payload_byte;
  assign out_frame_status  = res_q.frame_status;
  assign out_frame_address = res_q.frame_address;
  assign out_frame_control = res_q.frame_control;
  assign out_ack_request   = res_q.ack_request;
  assign out_ack_control   = res_q.ack_control;

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the async HDLC deframer with CRC-16/CCITT check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdlcd_pkg::*;

  localparam int PAYLOAD_MAX    = 1024;
  localparam int LEN_W          = $clog2(PAYLOAD_MAX + 1);
  localparam int FRAME_MAX      = PAYLOAD_MAX + 4;   // addr + ctrl + payload + 2 FCS
  localparam int RANDOM_BYTES   = 480;               // random part; the long frame adds ~1030
  localparam int WATCHDOG_LIMIT = 5000;              // quiet cycles before giving up
  localparam int DRAIN_CYCLES   = 20;                // well past the input and result registers
  localparam int REPORT_LIMIT   = 10;

  // One result transaction, all fields as seen on the out_ ports.
  typedef struct {
    logic             kind;
    logic [7:0]       payload_byte;
    logic [1:0]       frame_status;
    logic [7:0]       frame_address;
    logic [7:0]       frame_control;
    logic [LEN_W-1:0] payload_length;
    logic             ack_request;
    logic [2:0]       ack_control;
  } frame_result_t;

  // Tracks the deframer state per accepted byte and holds the results it should produce.
  class hdlc_rx_checker;
    frame_result_t pending_results[$];
    int unsigned   frame_bytes;
    bit            escaped;
    logic [15:0]   crc;
    logic [7:0]    addr_hold;
    logic [7:0]    ctrl_hold;
    logic [7:0]    tail[2];
    int unsigned   frame_max;
    int unsigned   mismatches;

    function new(int unsigned fmax);
      frame_max  = fmax;
      mismatches = 0;
      tail[0]    = '0;
      tail[1]    = '0;
      clear_frame();
    endfunction

    // reflected CRC-16, LSB first, one bit at a time
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void clear_frame();
      frame_bytes = 0;
      escaped     = 1'b0;
      crc         = CRC_INIT;
      addr_hold   = '0;
      ctrl_hold   = '0;
    endfunction

    function void take_byte(logic [7:0] raw);
      frame_result_t r;
      logic [7:0]    b;
      logic [7:0]    oldest;
      r = '{default: '0};
      if (raw == FLAG_BYTE) begin
        if (frame_bytes == 0) begin
          escaped = 1'b0;
          return;
        end
        r.kind = KIND_STATUS;
        if (frame_bytes > frame_max)  r.frame_status = ST_OVERFLOW;
        else if (frame_bytes < 4)     r.frame_status = ST_SHORT;
        else if (crc != CRC_GOOD)     r.frame_status = ST_CRC_ERR;
        else                          r.frame_status = ST_GOOD;
        r.frame_address = addr_hold;
        r.frame_control = ctrl_hold;
        if (r.frame_status == ST_GOOD) begin
          r.payload_length = LEN_W'(frame_bytes - 4);
          if (!ctrl_hold[0]) begin
            r.ack_request = 1'b1;
            r.ack_control = ctrl_hold[3:1] & ACK_MASK;
          end
        end
        pending_results.push_back(r);
        clear_frame();
        return;
      end
      if (raw == ESC_BYTE) begin
        escaped = 1'b1;
        return;
      end
      b       = escaped ? (raw ^ ESC_XOR) : raw;
      escaped = 1'b0;
      if (frame_bytes >= frame_max) begin
        frame_bytes = frame_max + 1;    // sticks here until the flag
        return;
      end
      crc = crc_next(crc, b);
      if (frame_bytes == 0) begin
        addr_hold = b;
      end else if (frame_bytes == 1) begin
        ctrl_hold = b;
      end else begin
        // two-byte delay keeps the FCS from going out as payload
        oldest  = tail[0];
        tail[0] = tail[1];
        tail[1] = b;
        if (frame_bytes >= 4) begin
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = oldest;
          pending_results.push_back(r);
        end
      end
      frame_bytes++;
    endfunction

    function string show(frame_result_t r);
      return $sformatf("kind=%0d byte=%02h status=%0d addr=%02h ctrl=%02h len=%0d ack=%0d/%0d",
                       r.kind, r.payload_byte, r.frame_status, r.frame_address,
                       r.frame_control, r.payload_length, r.ack_request, r.ack_control);
    endfunction

    function void match_result(frame_result_t got);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("unexpected result: %s", show(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
          got.frame_status !== want.frame_status ||
          got.frame_address !== want.frame_address ||
          got.frame_control !== want.frame_control ||
          got.payload_length !== want.payload_length ||
          got.ack_request !== want.ack_request || got.ack_control !== want.ack_control) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic [7:0]       in_rx_byte = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             out_kind;
  logic [7:0]       out_payload_byte;
  logic [1:0]       out_frame_status;
  logic [7:0]       out_frame_address;
  logic [7:0]       out_frame_control;
  logic [LEN_W-1:0] out_payload_length;
  logic             out_ack_request;
  logic [2:0]       out_ack_control;

  hdlc_deframer_crc16_check_top #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_frame_status  (out_frame_status),
    .out_frame_address (out_frame_address),
    .out_frame_control (out_frame_control),
    .out_payload_length(out_payload_length),
    .out_ack_request   (out_ack_request),
    .out_ack_control   (out_ack_control)
  );

  // 12 ns period
  always #6 clk = ~clk;

  hdlc_rx_checker rx_check = new(FRAME_MAX);

  int          sender_idle_pct = 0;   // chance per byte slot that the sender idles
  int          recv_stall_pct  = 0;   // chance per cycle that the receiver stalls
  int unsigned bytes_sent      = 0;
  int unsigned quiet_cycles    = 0;

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the edge, before any NBA of this step
  // lands. Input is noted first so a same-edge result always finds its
  // expectation (a byte passes both the input and result registers anyway).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_result_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall) rx_check.take_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        seen.kind           = out_kind;
        seen.payload_byte   = out_payload_byte;
        seen.frame_status   = out_frame_status;
        seen.frame_address  = out_frame_address;
        seen.frame_control  = out_frame_control;
        seen.payload_length = out_payload_length;
        seen.ack_request    = out_ack_request;
        seen.ack_control    = out_ack_control;
        rx_check.match_result(seen);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Receiver back-pressure: free-running random stall, may change any cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: nothing moved on either channel for too long.
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. Called at a rising edge; return at the edge that accepted the
  // byte, with in_valid still high so back-to-back bytes need no extra NBA.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // payload content biased toward the two bytes that need stuffing
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Well-formed frame: addr, ctrl, payload, FCS (low byte first), stuffed,
  // closed by a flag. 'corrupt' flips one bit after the FCS is computed.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] ctrl,
                            input int plen, input bit corrupt);
    logic [7:0]  body[$];
    logic [15:0] fcs;
    logic [7:0]  x;
    int          k;
    body = {};
    body.push_back(addr);
    body.push_back(ctrl);
    for (k = 0; k < plen; k++) body.push_back(pick_byte());
    fcs = CRC_INIT;
    foreach (body[i]) fcs = hdlc_rx_checker::crc_next(fcs, body[i]);
    fcs = ~fcs;
    body.push_back(fcs[7:0]);
    body.push_back(fcs[15:8]);
    if (corrupt) begin
      k       = $urandom_range(body.size() - 1);
      body[k] = body[k] ^ (8'h01 << $urandom_range(7));
    end
    foreach (body[i]) begin
      x = body[i] ^ ESC_XOR;
      // mandatory escapes, plus the odd gratuitous one (never one that
      // would put a flag or escape on the wire after the escape byte)
      if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE ||
          (x != FLAG_BYTE && x != ESC_BYTE && $urandom_range(15) == 0)) begin
        send_byte(ESC_BYTE);
        send_byte(x);
      end else begin
        send_byte(body[i]);
      end
    end
    send_byte(FLAG_BYTE);
  endtask

  // Line noise: short runs heavy in flags and escapes, sometimes left open.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(3))
        0:       send_byte(FLAG_BYTE);
        1:       send_byte(ESC_BYTE);
        default: send_byte(8'($urandom_range(255)));
      endcase
    end
    if ($urandom_range(1)) send_byte(FLAG_BYTE);
  endtask

  // Directed opener: back-to-back flags (no result), a one-byte frame,
  // escape right before a flag, and a repeated escape inside a frame.
  localparam logic [7:0] OPENING[14] = '{
    FLAG_BYTE, FLAG_BYTE,
    8'h00, FLAG_BYTE,
    8'h11, ESC_BYTE, FLAG_BYTE,
    8'h01, ESC_BYTE, ESC_BYTE, 8'h5E, 8'hFF, 8'h80, FLAG_BYTE
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned target;
    int          pick;
    int          plen;
    logic [7:0]  fill;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    foreach (OPENING[i]) send_byte(OPENING[i]);
    send_frame(8'hFF, 8'h0E, 0, 1'b0);    // minimum good I-frame, ack control all ones
    send_frame(8'h00, 8'h01, 1, 1'b0);    // S-frame, no ack request
    send_frame(8'hA5, 8'h00, 2, 1'b1);    // bad FCS

    // one byte past the frame limit; plain bytes below 0x7D need no stuffing
    for (int n = 0; n < FRAME_MAX + 1; n++) begin
      fill = 8'($urandom_range(8'h7C));
      send_byte(fill);
    end
    send_byte(FLAG_BYTE);

    // random part in four flow-control phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin sender_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      target = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        plen = ($urandom_range(15) == 0) ? $urandom_range(64) : $urandom_range(8);
        if (pick < 72)
          send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), plen, 1'b0);
        else if (pick < 84)
          send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), plen, 1'b1);
        else
          send_noise();
      end
    end

    in_valid <= 1'b0;
    while (rx_check.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);   // catch any stray extra results

    if (rx_check.mismatches == 0 && rx_check.pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
